@@ rtl/swfr_pkg.sv @@
`timescale 1ns / 1ps

package swfr_pkg;

   localparam logic [7:0] SYNC_0 = 8'h55;  // 'U'
   localparam logic [7:0] SYNC_1 = 8'h4E;  // 'N'
   localparam logic [7:0] SYNC_2 = 8'h45;  // 'E'
   localparam logic [7:0] SYNC_3 = 8'h52;  // 'R'
   localparam logic [7:0] COLON  = 8'h3A;  // ':'

   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_GOOD     = 2'd1;
   localparam logic [1:0] KIND_BAD_CKS  = 2'd2;
   localparam logic [1:0] KIND_ZERO_LEN = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [7:0] position;
   } result_type;

endpackage

@@ rtl/sync_word_frame_receiver.sv @@
`timescale 1ns / 1ps

// Frame receiver for a byte stream framed as the sync word U N E R, a length
// byte (payload count plus one), a colon, the payload and an XOR checksum over
// everything before it. Takes one byte per clock cycle unless the result side
// stalls; each byte passes through an input register and then the deframer,
// whose single level of state update logic registers at most one result per
// byte. A stalled result holds the deframer, and after one more byte in the
// input register the input stalls too. Payload bytes come out with their
// index, the checksum byte yields frame good or checksum error with the
// payload count, and a length of zero is reported and dropped at once.

module sync_word_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic [7:0] rsp_position
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 core_ready;
   swfr_pkg::result_type result;

   assign req_ready = !in_valid_ff || core_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (core_ready) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   swfr_deframer u_deframer (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid_ff),
      .in_byte    (in_byte_ff),
      .in_ready   (core_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (result)
   );

   assign rsp_kind     = result.kind;
   assign rsp_data     = result.data;
   assign rsp_position = result.position;

endmodule

@@ rtl/swfr_deframer.sv @@
`timescale 1ns / 1ps

module swfr_deframer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [7:0]              in_byte,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output swfr_pkg::result_type    out_result
);

   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_N     = 3'd1;
   localparam logic [2:0] PH_E     = 3'd2;
   localparam logic [2:0] PH_R     = 3'd3;
   localparam logic [2:0] PH_LEN   = 3'd4;
   localparam logic [2:0] PH_COLON = 3'd5;
   localparam logic [2:0] PH_BODY  = 3'd6;

   localparam logic [7:0] HDR_XOR = swfr_pkg::SYNC_0 ^ swfr_pkg::SYNC_1 ^ swfr_pkg::SYNC_2
                                  ^ swfr_pkg::SYNC_3 ^ swfr_pkg::COLON;

   logic [2:0]           phase_ff, phase_in;
   logic [7:0]           remaining_ff, remaining_in;
   logic [7:0]           xor_ff, xor_in;
   logic [7:0]           index_ff, index_in;
   logic                 out_valid_ff, out_valid_in;
   swfr_pkg::result_type result_ff, result_in;
   logic                 emit;
   logic                 take;
   logic [2:0]           hunt;
   logic [7:0]           rem_dec;

   assign in_ready   = !out_valid_ff || out_ready;
   assign take       = in_valid && in_ready;
   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

   // a mismatched byte is looked at again as a possible start of frame
   assign hunt    = (in_byte == swfr_pkg::SYNC_0) ? PH_N : PH_HUNT;
   assign rem_dec = remaining_ff - 8'd1;

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      xor_in       = xor_ff;
      index_in     = index_ff;
      emit         = 1'b0;
      result_in    = '0;
      case (phase_ff)
         PH_N: begin
            phase_in = (in_byte == swfr_pkg::SYNC_1) ? PH_E : hunt;
         end
         PH_E: begin
            phase_in = (in_byte == swfr_pkg::SYNC_2) ? PH_R : hunt;
         end
         PH_R: begin
            phase_in = (in_byte == swfr_pkg::SYNC_3) ? PH_LEN : hunt;
         end
         PH_LEN: begin
            if (in_byte == 8'd0) begin
               phase_in       = PH_HUNT;
               emit           = 1'b1;
               result_in.kind = swfr_pkg::KIND_ZERO_LEN;
            end else begin
               remaining_in = in_byte;
               phase_in     = PH_COLON;
            end
         end
         PH_COLON: begin
            if (in_byte == swfr_pkg::COLON) begin
               phase_in = PH_BODY;
               index_in = 8'd0;
               xor_in   = HDR_XOR ^ remaining_ff;
            end else begin
               phase_in = hunt;
            end
         end
         PH_BODY: begin
            remaining_in = rem_dec;
            emit         = 1'b1;
            result_in.data = in_byte;
            if (rem_dec != 8'd0) begin
               xor_in             = xor_ff ^ in_byte;
               index_in           = index_ff + 8'd1;
               result_in.kind     = swfr_pkg::KIND_PAYLOAD;
               result_in.position = index_ff;
            end else begin
               phase_in           = PH_HUNT;
               result_in.kind     = (xor_ff == in_byte) ? swfr_pkg::KIND_GOOD
                                                        : swfr_pkg::KIND_BAD_CKS;
               result_in.position = index_ff;
            end
         end
         default: begin
            phase_in = hunt;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_ready) begin
         out_valid_in = 1'b0;
      end
      if (take && emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         remaining_ff <= 8'd0;
         xor_ff       <= 8'd0;
         index_ff     <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            phase_ff     <= phase_in;
            remaining_ff <= remaining_in;
            xor_ff       <= xor_in;
            index_ff     <= index_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         result_ff <= result_in;
      end
   end

endmodule
